>>> rtl/breathing_led_pwm_top_defines.svh
// Assertion helpers for the top module, which checks its own logic.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef BREATHING_LED_PWM_TOP_DEFINES_SVH
`define BREATHING_LED_PWM_TOP_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define BLPWM_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blpwm same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define BLPWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blpwm next-cycle check failed");

`endif

>>> rtl/blpwm_pkg.sv
package blpwm_pkg;

    localparam int unsigned DATA_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PERIOD        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RAMP_PRESCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HOLD_RELOAD   = 2'd2;

    localparam logic [DATA_W-1:0] PERIOD_RESET        = 8'd20;
    localparam logic [DATA_W-1:0] RAMP_PRESCALE_RESET = 8'd60;
    localparam logic [DATA_W-1:0] HOLD_RELOAD_RESET   = 8'd30;

    localparam logic [DATA_W-1:0] DUTY_RESET = 8'd20;
    localparam logic [DATA_W-1:0] HOLD_RESET = 8'd10;

    typedef struct packed {
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] ramp_prescale;
        logic [DATA_W-1:0] hold_reload;
    } cfg_t;

    typedef struct packed {
        logic              pin_level;
        logic [DATA_W-1:0] duty_now;
        logic              rising;
    } res_t;

endpackage

>>> rtl/breathing_led_pwm_top.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+----------------------------------
// input    | in_valid / in_ready  | pwm_tick, ramp_tick
// output   | out_valid / out_ready| pin_level, duty_now, rising
// config   | cfg_we (no wait)     | cfg_index, cfg_data
//
// One item is taken per cycle while in_ready is high.
// The tick stage register feeds the state update, which writes the result register.
// Reset loads the default register values and the initial ramp state.
// A stalled result holds in the result register while one more item waits in the tick stage.
// in_ready drops only when both stages are full and out_ready is low.
`include "breathing_led_pwm_top_defines.svh"

module breathing_led_pwm_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                pwm_tick,
    input  logic                                ramp_tick,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                pin_level,
    output logic [blpwm_pkg::DATA_W-1:0]        duty_now,
    output logic                                rising,
    input  logic                                cfg_we,
    input  logic [blpwm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [blpwm_pkg::DATA_W-1:0]        cfg_data
);
    import blpwm_pkg::*;

    cfg_t cfg;
    res_t core_res;

    logic s1_valid_reg, s1_valid_next;
    logic pwm_tick_reg, pwm_tick_next;
    logic ramp_tick_reg, ramp_tick_next;
    logic out_valid_reg, out_valid_next;
    res_t res_reg, res_next;

    logic s1_adv;
    logic in_xfer;

    blpwm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    blpwm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (s1_adv),
        .pwm_tick  (pwm_tick_reg),
        .ramp_tick (ramp_tick_reg),
        .cfg       (cfg),
        .res       (core_res)
    );

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        pwm_tick_next  = pwm_tick_reg;
        ramp_tick_next = ramp_tick_reg;
        if (in_xfer)
        begin
            s1_valid_next  = 1'b1;
            pwm_tick_next  = pwm_tick;
            ramp_tick_next = ramp_tick;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
            res_next       = core_res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pwm_tick_reg  <= pwm_tick_next;
        ramp_tick_reg <= ramp_tick_next;
        res_reg       <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign pin_level = res_reg.pin_level;
    assign duty_now  = res_reg.duty_now;
    assign rising    = res_reg.rising;

    `BLPWM_ASSERT_IMPLIES(a_ready_when_out_empty, !out_valid_reg, in_ready)
    `BLPWM_ASSERT_NEXT(a_stage_holds_on_stall, s1_valid_reg && !s1_adv, s1_valid_reg)
    `BLPWM_ASSERT_NEXT(a_result_holds_unless_loaded, out_valid_reg && !s1_adv, $stable(res_reg))

endmodule

>>> rtl/blpwm_cfg.sv
module blpwm_cfg (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [blpwm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [blpwm_pkg::DATA_W-1:0]           cfg_data,
    output blpwm_pkg::cfg_t                        cfg
);
    import blpwm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDX_PERIOD:        cfg_next.period        = cfg_data;
                CFG_IDX_RAMP_PRESCALE: cfg_next.ramp_prescale = cfg_data;
                CFG_IDX_HOLD_RELOAD:   cfg_next.hold_reload   = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period        <= PERIOD_RESET;
            cfg_reg.ramp_prescale <= RAMP_PRESCALE_RESET;
            cfg_reg.hold_reload   <= HOLD_RELOAD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/blpwm_core.sv
module blpwm_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  logic             pwm_tick,
    input  logic             ramp_tick,
    input  blpwm_pkg::cfg_t  cfg,
    output blpwm_pkg::res_t  res
);
    import blpwm_pkg::*;

    logic [DATA_W-1:0] pwm_count_reg, pwm_count_next;
    logic              pin_reg, pin_next;
    logic [DATA_W-1:0] duty_reg, duty_next;
    logic              dir_up_reg, dir_up_next;
    logic [DATA_W-1:0] up_pre_reg, up_pre_next;
    logic [DATA_W-1:0] down_pre_reg, down_pre_next;
    logic [DATA_W-1:0] hold_reg, hold_next;

    always_comb
    begin
        pwm_count_next = pwm_count_reg;
        pin_next       = pin_reg;
        duty_next      = duty_reg;
        dir_up_next    = dir_up_reg;
        up_pre_next    = up_pre_reg;
        down_pre_next  = down_pre_reg;
        hold_next      = hold_reg;

        // The PWM step compares against the duty held before this tick.
        if (step_en && pwm_tick)
        begin
            if (pwm_count_reg >= cfg.period)
            begin
                pin_next       = 1'b0;
                pwm_count_next = '0;
            end
            else
            begin
                if (pwm_count_reg == duty_reg)
                begin
                    pin_next = 1'b1;
                end
                pwm_count_next = pwm_count_reg + 8'd1;
            end
        end

        if (step_en && ramp_tick)
        begin
            if (dir_up_reg)
            begin
                if (up_pre_reg >= cfg.ramp_prescale)
                begin
                    up_pre_next = '0;
                    if (duty_reg < cfg.period)
                    begin
                        duty_next = duty_reg + 8'd1;
                    end
                    else if (hold_reg != '0)
                    begin
                        duty_next = cfg.period;
                        hold_next = hold_reg - 8'd1;
                    end
                    else
                    begin
                        dir_up_next = 1'b0;
                        hold_next   = cfg.hold_reload;
                    end
                end
                else
                begin
                    up_pre_next = up_pre_reg + 8'd1;
                end
            end
            else
            begin
                if (down_pre_reg >= cfg.ramp_prescale)
                begin
                    down_pre_next = '0;
                    if (duty_reg != '0)
                    begin
                        duty_next = duty_reg - 8'd1;
                    end
                    else if (hold_reg != '0)
                    begin
                        duty_next = '0;
                        hold_next = hold_reg - 8'd1;
                    end
                    else
                    begin
                        dir_up_next = 1'b1;
                        hold_next   = cfg.hold_reload;
                    end
                end
                else
                begin
                    down_pre_next = down_pre_reg + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_count_reg <= '0;
            pin_reg       <= 1'b0;
            duty_reg      <= DUTY_RESET;
            dir_up_reg    <= 1'b0;
            up_pre_reg    <= '0;
            down_pre_reg  <= '0;
            hold_reg      <= HOLD_RESET;
        end
        else
        begin
            pwm_count_reg <= pwm_count_next;
            pin_reg       <= pin_next;
            duty_reg      <= duty_next;
            dir_up_reg    <= dir_up_next;
            up_pre_reg    <= up_pre_next;
            down_pre_reg  <= down_pre_next;
            hold_reg      <= hold_next;
        end
    end

    always_comb
    begin
        res.pin_level = pin_next;
        res.duty_now  = duty_next;
        res.rising    = dir_up_next;
    end

endmodule

>>> tb/sv/breathing_led_pwm_checker.sv
module breathing_led_pwm_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            pwm_tick,
    input  logic                            ramp_tick,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            pin_level,
    input  logic [blpwm_pkg::DATA_W-1:0]    duty_now,
    input  logic                            rising,
    input  logic                            cfg_we,
    input  logic [blpwm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [blpwm_pkg::DATA_W-1:0]    cfg_data,
    output int unsigned                     fail_count,
    output int unsigned                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import blpwm_pkg::*;

    cfg_t              led_cfg;
    logic [DATA_W-1:0] pwm_cnt;
    logic              pin;
    logic [DATA_W-1:0] duty;
    logic              dir_up;
    logic [DATA_W-1:0] up_pre;
    logic [DATA_W-1:0] down_pre;
    logic [DATA_W-1:0] hold_cnt;
    res_t              expected_levels[$];
    int unsigned       reported;

    function void step_pwm_counter();
        if (pwm_cnt >= led_cfg.period)
        begin
            pin = 1'b0;
            pwm_cnt = '0;
        end
        else
        begin
            if (pwm_cnt == duty)
                pin = 1'b1;
            pwm_cnt = pwm_cnt + 8'd1;
        end
    endfunction

    function void settle_end_stop(input logic [DATA_W-1:0] stop_value, input logic new_dir);
        if (hold_cnt != 0)
        begin
            duty = stop_value;
            hold_cnt = hold_cnt - 8'd1;
        end
        else
        begin
            dir_up = new_dir;
            hold_cnt = led_cfg.hold_reload;
        end
    endfunction

    function void step_duty_ramp();
        if (dir_up)
        begin
            if (up_pre >= led_cfg.ramp_prescale)
            begin
                up_pre = '0;
                if (duty < led_cfg.period)
                    duty = duty + 8'd1;
                else
                    settle_end_stop(led_cfg.period, 1'b0);
            end
            else
                up_pre = up_pre + 8'd1;
        end
        else
        begin
            if (down_pre >= led_cfg.ramp_prescale)
            begin
                down_pre = '0;
                if (duty > 0)
                    duty = duty - 8'd1;
                else
                    settle_end_stop('0, 1'b1);
            end
            else
                down_pre = down_pre + 8'd1;
        end
    endfunction

    // The PWM step runs before the ramp step, so it sees the old duty.
    function res_t next_led_levels(input logic do_pwm, input logic do_ramp);
        res_t levels;
        if (do_pwm)
            step_pwm_counter();
        if (do_ramp)
            step_duty_ramp();
        levels.pin_level = pin;
        levels.duty_now = duty;
        levels.rising = dir_up;
        return levels;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            led_cfg.period = PERIOD_RESET;
            led_cfg.ramp_prescale = RAMP_PRESCALE_RESET;
            led_cfg.hold_reload = HOLD_RELOAD_RESET;
            pwm_cnt = '0;
            pin = 1'b0;
            duty = DUTY_RESET;
            dir_up = 1'b0;
            up_pre = '0;
            down_pre = '0;
            hold_cnt = HOLD_RESET;
            expected_levels.delete();
            reported = 0;
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IDX_PERIOD:        led_cfg.period = cfg_data;
                    CFG_IDX_RAMP_PRESCALE: led_cfg.ramp_prescale = cfg_data;
                    CFG_IDX_HOLD_RELOAD:   led_cfg.hold_reload = cfg_data;
                    default:               ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got.pin_level = pin_level;
                got.duty_now = duty_now;
                got.rising = rising;
                if (expected_levels.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (reported < 10)
                        $display("%0t: unexpected result transfer pin=%0b duty=%0d rising=%0b",
                                 $time, got.pin_level, got.duty_now, got.rising);
                    reported++;
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (got.pin_level !== want.pin_level || got.duty_now !== want.duty_now
                        || got.rising !== want.rising)
                    begin
                        fail_count <= fail_count + 1;
                        if (reported < 10)
                            $display({"%0t: mismatch expected pin=%0b duty=%0d rising=%0b,",
                                      " got pin=%0b duty=%0d rising=%0b"},
                                     $time, want.pin_level, want.duty_now, want.rising,
                                     got.pin_level, got.duty_now, got.rising);
                        reported++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_levels.push_back(next_led_levels(pwm_tick, ramp_tick));
            outstanding <= expected_levels.size();
        end
    end

endmodule

>>> tb/sv/tb_breathing_led_pwm_top.sv
module tb_breathing_led_pwm_top;
    timeunit 1ns;
    timeprecision 1ps;

    import blpwm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 pwm_tick;
    logic                 ramp_tick;
    logic                 out_valid;
    logic                 out_ready;
    logic                 pin_level;
    logic [DATA_W-1:0]    duty_now;
    logic                 rising;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    int unsigned          fail_count;
    int unsigned          outstanding;
    int unsigned          cycles = 0;
    bit                   no_idle;

    breathing_led_pwm_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pwm_tick  (pwm_tick),
        .ramp_tick (ramp_tick),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pin_level (pin_level),
        .duty_now  (duty_now),
        .rising    (rising),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    breathing_led_pwm_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pwm_tick    (pwm_tick),
        .ramp_tick   (ramp_tick),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pin_level   (pin_level),
        .duty_now    (duty_now),
        .rising      (rising),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : result_sink
        int unsigned stall;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_ticks(input logic do_pwm, input logic do_ramp);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pwm_tick <= do_pwm;
        ramp_tick <= do_ramp;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic load_regs(input logic [DATA_W-1:0] per, input logic [DATA_W-1:0] pre,
                             input logic [DATA_W-1:0] hold, input bit with_spare);
        cfg_we <= 1'b1;
        cfg_index <= CFG_IDX_PERIOD;
        cfg_data <= per;
        @(posedge clk);
        cfg_index <= CFG_IDX_RAMP_PRESCALE;
        cfg_data <= pre;
        @(posedge clk);
        cfg_index <= CFG_IDX_HOLD_RELOAD;
        cfg_data <= hold;
        @(posedge clk);
        if (with_spare)
        begin
            cfg_index <= CFG_IDX_SPARE;
            cfg_data <= 8'hFF;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Ramp ticks are favored so that the duty reaches its end stops and reverses.
    task automatic run_ticks(input int unsigned count);
        no_idle = ($urandom_range(0, 3) == 0);
        repeat (count)
            send_ticks(1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
        drain_results();
    endtask

    initial
    begin
        no_idle = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pwm_tick = 1'b0;
        ramp_tick = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_ticks(1'b0, 1'b0);
        send_ticks(1'b1, 1'b0);
        send_ticks(1'b0, 1'b1);
        send_ticks(1'b1, 1'b1);
        drain_results();

        // A zero period wraps on every PWM step; the spare index must be ignored.
        load_regs(8'd0, 8'd0, 8'd0, 1'b1);
        send_ticks(1'b1, 1'b0);
        send_ticks(1'b1, 1'b1);
        send_ticks(1'b0, 1'b1);
        send_ticks(1'b1, 1'b1);
        send_ticks(1'b0, 1'b0);
        send_ticks(1'b0, 1'b1);
        drain_results();

        load_regs(8'd255, 8'd255, 8'd255, 1'b0);
        repeat (3) send_ticks(1'b1, 1'b1);
        repeat (2) send_ticks(1'b0, 1'b1);
        drain_results();

        load_regs(8'd1, 8'd0, 8'd1, 1'b0);
        repeat (8) send_ticks(1'b1, 1'b1);
        drain_results();

        load_regs(PERIOD_RESET, RAMP_PRESCALE_RESET, HOLD_RELOAD_RESET, 1'b0);
        run_ticks(120);
        load_regs(8'd3, 8'd0, 8'd0, 1'b0);
        run_ticks(180);
        load_regs(8'd255, 8'd0, 8'd2, 1'b0);
        run_ticks(200);
        load_regs(8'd6, 8'd0, 8'd4, 1'b0);
        run_ticks(160);
        load_regs(8'd1, 8'd0, 8'd255, 1'b0);
        run_ticks(120);
        load_regs(8'd0, 8'd1, 8'd3, 1'b0);
        run_ticks(120);
        load_regs(8'd10, 8'd2, 8'd1, 1'b0);
        run_ticks(200);
        load_regs(8'd255, 8'd255, 8'd0, 1'b0);
        run_ticks(100);
        repeat (4)
        begin
            load_regs(8'($urandom_range(0, 12)), 8'($urandom_range(0, 3)),
                      8'($urandom_range(0, 5)), 1'b0);
            run_ticks(160);
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/blpwm_pkg.sv
rtl/blpwm_cfg.sv
rtl/blpwm_core.sv
rtl/breathing_led_pwm_top.sv
tb/sv/breathing_led_pwm_checker.sv
tb/sv/tb_breathing_led_pwm_top.sv
